FILE: hw/rtl/basic_auth_header_base64_decoder_macros.svh
// ---------------------------------------------------------------------------
// Basic auth decoder assertion macros
// Shared helpers for concurrent checks clocked on the block clock.
// ---------------------------------------------------------------------------
`ifndef BASIC_AUTH_HEADER_BASE64_DECODER_MACROS_SVH
`define BASIC_AUTH_HEADER_BASE64_DECODER_MACROS_SVH

// same-cycle implication
`define BAHD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bahd check failed");

// next-cycle implication
`define BAHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bahd check failed");

`endif

FILE: hw/rtl/bahd_pkg.sv
// ---------------------------------------------------------------------------
// Basic auth decoder package
// Types, character codes and lookup functions for the header decoder.
// ---------------------------------------------------------------------------
package bahd_pkg;

   localparam int unsigned CAP_W = 10;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_PAD   = 8'h3D;

   localparam logic [6:0] B64_PAD = 7'd64;
   localparam logic [6:0] B64_BAD = 7'd65;

   localparam logic [2:0] SCHEME_LEN = 3'd5;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 10'd102;

   localparam logic CSR_DECODE_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      PH_START,
      PH_LEAD,
      PH_SCHEME,
      PH_NEEDBLANK,
      PH_SKIPBLANK,
      PH_DATA,
      PH_PAD,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_MISSING,
      STATUS_MALFORMED
   } status_type;

   typedef enum logic {
      KIND_DATA,
      KIND_STATUS
   } kind_type;

   typedef struct packed {
      phase_type        phase;
      logic [2:0]       scheme_index;
      logic [5:0]       leftover_bits;
      logic [2:0]       leftover_count;
      logic [CAP_W-1:0] byte_count;
   } state_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data_byte;
      status_type       status;
      logic [CAP_W-1:0] decoded_length;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:          PH_START,
      scheme_index:   3'd0,
      leftover_bits:  6'd0,
      leftover_count: 3'd0,
      byte_count:     '0
   };

   // 0..63 for alphabet, B64_PAD for '=', B64_BAD otherwise
   function automatic logic [6:0] b64_value(input logic [7:0] c);
      logic [6:0] v;
      v = B64_BAD;
      if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
      else if (c == 8'h2B) v = 7'd62;
      else if (c == 8'h2F) v = 7'd63;
      else if (c == CHAR_PAD) v = B64_PAD;
      return v;
   endfunction

   // lower-case letters of the scheme word "basic"
   function automatic logic [7:0] scheme_letter(input logic [2:0] idx);
      logic [7:0] l;
      case (idx)
         3'd0:    l = 8'h62;
         3'd1:    l = 8'h61;
         3'd2:    l = 8'h73;
         3'd3:    l = 8'h69;
         3'd4:    l = 8'h63;
         default: l = 8'h00;
      endcase
      return l;
   endfunction

endpackage

FILE: hw/rtl/bahd_step.sv
// ---------------------------------------------------------------------------
// Basic auth decoder step
// Next-state and result logic for one header character or end marker.
// ---------------------------------------------------------------------------
module bahd_step
   import bahd_pkg::*;
(
   input  state_type        cur,
   input  logic [7:0]       char_byte,
   input  logic             end_of_text,
   input  logic [CAP_W-1:0] capacity,
   output state_type        nxt,
   output logic             emit,
   output result_type       result
);

   logic       blank;
   logic [7:0] lc;
   logic       scheme_ok;
   logic [2:0] idx_inc;
   logic [6:0] v;
   logic [11:0] bits;
   logic       do_scheme;
   logic       do_data;

   always_comb begin
      blank     = (char_byte == CHAR_SPACE) || (char_byte == CHAR_TAB);
      lc        = (char_byte >= 8'h41 && char_byte <= 8'h5A) ? char_byte + 8'h20 : char_byte;
      scheme_ok = (cur.scheme_index < SCHEME_LEN) && (lc == scheme_letter(cur.scheme_index));
      idx_inc   = cur.scheme_index + 3'd1;
      v         = b64_value(char_byte);
      bits      = {cur.leftover_bits, v[5:0]};
      do_scheme = 1'b0;
      do_data   = 1'b0;
      nxt       = cur;
      emit      = 1'b0;
      result    = '0;

      if (end_of_text) begin
         emit        = 1'b1;
         result.kind = KIND_STATUS;
         nxt         = STATE_RESET;
         unique case (cur.phase) inside
            PH_START: result.status = STATUS_MISSING;
            PH_DATA, PH_PAD: begin
               if (cur.leftover_count >= 3'd6) begin
                  result.status = STATUS_MALFORMED;
               end else begin
                  result.status         = STATUS_OK;
                  result.decoded_length = cur.byte_count;
               end
            end
            default: result.status = STATUS_MALFORMED;
         endcase
      end else begin
         unique case (cur.phase) inside
            PH_START, PH_LEAD: begin
               if (blank) nxt.phase = PH_LEAD;
               else do_scheme = 1'b1;
            end
            PH_SCHEME:    do_scheme = 1'b1;
            PH_NEEDBLANK: nxt.phase = blank ? PH_SKIPBLANK : PH_ERROR;
            PH_SKIPBLANK: do_data = !blank;
            PH_DATA:      do_data = 1'b1;
            PH_PAD: begin
               if (char_byte != CHAR_PAD) nxt.phase = PH_ERROR;
            end
            default: ;
         endcase

         if (do_scheme) begin
            if (!scheme_ok) begin
               nxt.phase = PH_ERROR;
            end else begin
               nxt.scheme_index = idx_inc;
               nxt.phase        = (idx_inc == SCHEME_LEN) ? PH_NEEDBLANK : PH_SCHEME;
            end
         end

         if (do_data) begin
            if (v == B64_PAD) begin
               nxt.phase = PH_PAD;
            end else if (v == B64_BAD) begin
               nxt.phase = PH_ERROR;
            end else begin
               nxt.phase = PH_DATA;
               if (cur.leftover_count >= 3'd2) begin
                  // a byte completes; over capacity it is dropped and the header fails
                  if (cur.byte_count >= capacity) begin
                     nxt.phase = PH_ERROR;
                  end else begin
                     emit           = 1'b1;
                     result.kind    = KIND_DATA;
                     nxt.byte_count = cur.byte_count + CAP_W'(1);
                     case (cur.leftover_count)
                        3'd6: begin
                           result.data_byte   = bits[11:4];
                           nxt.leftover_bits  = {2'b00, bits[3:0]};
                           nxt.leftover_count = 3'd4;
                        end
                        3'd4: begin
                           result.data_byte   = bits[9:2];
                           nxt.leftover_bits  = {4'b0000, bits[1:0]};
                           nxt.leftover_count = 3'd2;
                        end
                        default: begin
                           result.data_byte   = bits[7:0];
                           nxt.leftover_bits  = 6'd0;
                           nxt.leftover_count = 3'd0;
                        end
                     endcase
                  end
               end else begin
                  nxt.leftover_bits  = v[5:0];
                  nxt.leftover_count = 3'd6;
               end
            end
         end
      end
   end

endmodule

FILE: hw/rtl/basic_auth_header_base64_decoder.sv
// ---------------------------------------------------------------------------
// Basic auth header base64 decoder
// Parses "Basic <base64>" one character per request and streams out bytes.
// ---------------------------------------------------------------------------
// Accepts one request per clock unless a waiting result stalls it. A request
// is captured in an input register, decoded against the header state, and
// any result lands in the output register. Each character yields at most
// one decoded byte; the end marker yields one status (ok with length,
// missing, or malformed). The output register stalls the input register
// only while a result waits.
// ---------------------------------------------------------------------------
`include "basic_auth_header_base64_decoder_macros.svh"

module basic_auth_header_base64_decoder
   import bahd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_char_byte,
   input  logic             req_end_of_text,

   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [1:0]       rsp_status,
   output logic [CAP_W-1:0] rsp_decoded_length,

   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_char_ff;
   logic             s1_eot_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff;
   state_type        state_ff;
   logic [CAP_W-1:0] capacity_ff;

   logic       out_free;
   logic       s1_fire;
   logic       req_fire;
   state_type  state_in;
   logic       emit;
   result_type result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = out_free ? (s1_fire && emit) : rsp_valid_ff;
   end

   bahd_step u_step (
      .cur         (state_ff),
      .char_byte   (s1_char_ff),
      .end_of_text (s1_eot_ff),
      .capacity    (capacity_ff),
      .nxt         (state_in),
      .emit        (emit),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
         capacity_ff  <= CAPACITY_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) state_ff <= state_in;
         if (psel && penable && pwrite && pready && paddr[2] == CSR_DECODE_CAPACITY) begin
            capacity_ff <= pwdata[CAP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_char_ff <= req_char_byte;
         s1_eot_ff  <= req_end_of_text;
      end
      if (out_free) rsp_ff <= result;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_status         = rsp_ff.status;
   assign rsp_decoded_length = rsp_ff.decoded_length;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_DECODE_CAPACITY) ? {22'd0, capacity_ff} : 32'd0;

   // header state returns to start after every end marker
   `BAHD_ASSERT_NEXT(a_clear_after_end, clock, reset, s1_fire && s1_eot_ff,
      state_ff.phase == PH_START && state_ff.byte_count == '0 && state_ff.leftover_count == 3'd0)

   // leftover bit count only ever takes 0, 2, 4 or 6
   `BAHD_ASSERT_NOW(a_leftover_even, clock, reset, 1'b1,
      !state_ff.leftover_count[0] && state_ff.leftover_count <= 3'd6)

   // a stalled request stays in the input register untouched
   `BAHD_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !out_free,
      s1_valid_ff && $stable(s1_char_ff) && $stable(s1_eot_ff))

   // data results carry no status or length
   `BAHD_ASSERT_NOW(a_data_clean, clock, reset, rsp_valid_ff && rsp_ff.kind == KIND_DATA,
      rsp_ff.status == STATUS_OK && rsp_ff.decoded_length == '0)

endmodule

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// Basic auth header decoder testbench
// Streams Authorization headers into the decoder one character per request,
// with random idling on both channels, and checks every decoded byte and
// final status against a behavioral model of the parser held in the bench.
// ---------------------------------------------------------------------------
module testbench;
   import bahd_pkg::*;

   typedef struct {
      logic [7:0] ch;
      logic       eot;
   } header_item_type;

   localparam logic [39:0] SCHEME_WORD = "basic";
   localparam logic [2:0]  CAP_ADDR    = {CSR_DECODE_CAPACITY, 2'b00};
   localparam logic [2:0]  SPARE_ADDR  = 3'd4;
   localparam int          PHASES      = 6;
   localparam int          PHASE_ITEMS = 170;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_char_byte = 8'h00;
   logic             req_end_of_text = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_kind;
   logic [7:0]       rsp_data_byte;
   logic [1:0]       rsp_status;
   logic [CAP_W-1:0] rsp_decoded_length;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [2:0]       paddr = 3'd0;
   logic [31:0]      pwdata = 32'd0;
   logic [31:0]      prdata;
   logic             pready;

   basic_auth_header_base64_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_byte      (req_char_byte),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_status         (rsp_status),
      .rsp_decoded_length (rsp_decoded_length),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------
   // Header parser model
   // ------------------------------------------------------------------
   phase_type        hdr_phase = PH_START;
   logic [2:0]       match_idx = 3'd0;
   logic [5:0]       carry_bits = 6'd0;
   logic [2:0]       carry_count = 3'd0;
   logic [CAP_W-1:0] out_count = '0;
   logic [CAP_W-1:0] capacity_model = CAPACITY_RESET;
   result_type       predicted_results[$];

   header_item_type  header_chars[$];
   int               queued_count = 0;
   int               accepted_count = 0;
   int               mismatches = 0;
   bit               no_idle = 1'b0;
   bit               req_accepted = 1'b0;
   bit               rsp_accepted = 1'b0;
   int               send_gap = 0;
   int               recv_stall = 0;

   function automatic bit blank_char(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB;
   endfunction

   // 6-bit value, B64_PAD for '=', B64_BAD for anything outside the alphabet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] v;
      v = B64_BAD;
      case (1'b1)
         (c inside {["A":"Z"]}): v = 7'(c - "A");
         (c inside {["a":"z"]}): v = 7'(c - "a") + 7'd26;
         (c inside {["0":"9"]}): v = 7'(c - "0") + 7'd52;
         (c == "+"):             v = 7'd62;
         (c == "/"):             v = 7'd63;
         (c == CHAR_PAD):        v = B64_PAD;
         default:                v = B64_BAD;
      endcase
      return v;
   endfunction

   task automatic clear_header();
      hdr_phase   = PH_START;
      match_idx   = 3'd0;
      carry_bits  = 6'd0;
      carry_count = 3'd0;
      out_count   = '0;
   endtask

   task automatic match_scheme(input logic [7:0] c);
      logic [7:0] lc;
      lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
      if (match_idx > 3'd4 || lc != SCHEME_WORD[39 - 8*int'(match_idx) -: 8]) begin
         hdr_phase = PH_ERROR;
      end else begin
         match_idx = match_idx + 3'd1;
         hdr_phase = (match_idx == 3'd5) ? PH_NEEDBLANK : PH_SCHEME;
      end
   endtask

   task automatic take_payload(input logic [7:0] c);
      logic [6:0]  v;
      logic [11:0] acc;
      logic [3:0]  n;
      result_type  r;
      v = sextet_of(c);
      if (v == B64_PAD) begin
         hdr_phase = PH_PAD;
      end else if (v == B64_BAD) begin
         hdr_phase = PH_ERROR;
      end else begin
         hdr_phase = PH_DATA;
         acc = {carry_bits, v[5:0]};
         n = 4'(carry_count) + 4'd6;
         if (n >= 4'd8) begin
            n = n - 4'd8;
            if (out_count >= capacity_model) begin
               // byte would overflow the capacity: dropped, header is bad
               hdr_phase = PH_ERROR;
            end else begin
               r = '{kind: KIND_DATA, data_byte: 8'(acc >> n), status: STATUS_OK,
                     decoded_length: '0};
               predicted_results.push_back(r);
               out_count   = out_count + CAP_W'(1);
               carry_bits  = 6'(acc & ((12'd1 << n) - 12'd1));
               carry_count = n[2:0];
            end
         end else begin
            carry_bits  = v[5:0];
            carry_count = n[2:0];
         end
      end
   endtask

   task automatic decode_header_char(input logic [7:0] c, input logic eot);
      result_type r;
      if (eot) begin
         r = '{kind: KIND_STATUS, data_byte: 8'd0, status: STATUS_MALFORMED,
               decoded_length: '0};
         if (hdr_phase == PH_START) begin
            r.status = STATUS_MISSING;
         end else if ((hdr_phase == PH_DATA || hdr_phase == PH_PAD) && carry_count < 3'd6) begin
            r.status = STATUS_OK;
            r.decoded_length = out_count;
         end
         predicted_results.push_back(r);
         clear_header();
      end else begin
         case (hdr_phase) inside
            PH_START, PH_LEAD: begin
               if (blank_char(c)) hdr_phase = PH_LEAD;
               else match_scheme(c);
            end
            PH_SCHEME:    match_scheme(c);
            PH_NEEDBLANK: hdr_phase = blank_char(c) ? PH_SKIPBLANK : PH_ERROR;
            PH_SKIPBLANK: begin
               if (!blank_char(c)) take_payload(c);
            end
            PH_DATA:      take_payload(c);
            PH_PAD: begin
               if (c != CHAR_PAD) hdr_phase = PH_ERROR;
            end
            default: ;
         endcase
      end
   endtask

   // ------------------------------------------------------------------
   // Request driver and response ready
   // ------------------------------------------------------------------
   always @(negedge clock) begin : driver
      header_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (header_chars.size() > 0) begin
            item = header_chars.pop_front();
            req_valid       <= 1'b1;
            req_char_byte   <= item.ch;
            req_end_of_text <= item.eot;
            send_gap = no_idle ? 0 : $urandom_range(0, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (rsp_accepted) recv_stall = no_idle ? 0 : $urandom_range(0, 13);
      if (recv_stall > 0) begin
         recv_stall = recv_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on each request, compare each response
   // ------------------------------------------------------------------
   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches = mismatches + 1;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      req_accepted = 1'b0;
      rsp_accepted = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_accepted = 1'b1;
            accepted_count = accepted_count + 1;
            decode_header_char(req_char_byte, req_end_of_text);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_accepted = 1'b1;
            if (predicted_results.size() == 0) begin
               mismatches = mismatches + 1;
               $display("%0t: unexpected response, expected none, actual %h/%h/%h/%0d",
                        $time, rsp_kind, rsp_data_byte, rsp_status, rsp_decoded_length);
            end else begin
               want = predicted_results.pop_front();
               if (rsp_kind !== want.kind)
                  note_mismatch("kind", 32'(want.kind), 32'(rsp_kind));
               if (rsp_data_byte !== want.data_byte)
                  note_mismatch("data_byte", 32'(want.data_byte), 32'(rsp_data_byte));
               if (rsp_status !== want.status)
                  note_mismatch("status", 32'(want.status), 32'(rsp_status));
               if (rsp_decoded_length !== want.decoded_length)
                  note_mismatch("decoded_length", 32'(want.decoded_length),
                                32'(rsp_decoded_length));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic push_char(input logic [7:0] c);
      header_item_type item;
      item.ch  = c;
      item.eot = 1'b0;
      header_chars.push_back(item);
      queued_count = queued_count + 1;
   endtask

   task automatic push_end();
      header_item_type item;
      item.ch  = 8'($urandom_range(0, 255));
      item.eot = 1'b1;
      header_chars.push_back(item);
      queued_count = queued_count + 1;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      if (v < 6'd26) return 8'h41 + 8'(v);
      if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
      if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
      return (v == 6'd62) ? 8'h2B : 8'h2F;
   endfunction

   function automatic logic [7:0] rand_blank();
      return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
   endfunction

   task automatic push_random_header();
      logic [7:0]  hdr[$];
      logic [7:0]  letter;
      int unsigned sel;
      int unsigned n;
      int unsigned cut;
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
         // pure noise
         n = $urandom_range(0, 6);
         repeat (n) push_char(8'($urandom_range(0, 255)));
         push_end();
         return;
      end
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) hdr.push_back(rand_blank());
      for (int i = 0; i < 5; i++) begin
         letter = SCHEME_WORD[39 - 8*i -: 8];
         if ($urandom_range(0, 1)) letter = letter - 8'h20;
         hdr.push_back(letter);
      end
      n = (sel == 4) ? 0 : $urandom_range(1, 3);
      repeat (n) hdr.push_back(rand_blank());
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
      repeat (n) hdr.push_back(b64_char(6'($urandom_range(0, 63))));
      n = $urandom_range(0, 3);
      repeat (n) hdr.push_back(CHAR_PAD);
      case (sel)
         1: hdr[$urandom_range(0, hdr.size() - 1)] = 8'($urandom_range(0, 255));
         2: begin
            cut = $urandom_range(0, hdr.size());
            while (hdr.size() > cut) void'(hdr.pop_back());
         end
         3: begin
            hdr.push_back(CHAR_PAD);
            hdr.push_back(b64_char(6'($urandom_range(0, 63))));
         end
         default: ;
      endcase
      foreach (hdr[i]) push_char(hdr[i]);
      push_end();
   endtask

   // everything sent, every response back, and the pipe given time to empty
   task automatic wait_drained();
      while (accepted_count != queued_count || predicted_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == CAP_ADDR) capacity_model = data[CAP_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      int target;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed headers at the reset capacity
      push_end();                       // empty header
      push_text("\t");                  // blanks only
      push_end();
      push_char(8'h00);                 // NUL is just a bad character
      push_end();
      push_char(8'h62);                 // scheme broken by a high character
      push_char(8'hFF);
      push_end();
      push_text("BASIC\t=");            // padding only
      push_end();
      push_text("basic /+9a=Z");        // bytes, then data after padding
      push_end();

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            case (p)
               1: write_csr(CAP_ADDR, 32'd0);
               2: begin
                  write_csr(SPARE_ADDR, $urandom);
                  write_csr(CAP_ADDR, 32'd60);
               end
               3: write_csr(CAP_ADDR, 32'($urandom_range(1, 12)));
               4: write_csr(CAP_ADDR, $urandom);
               default: write_csr(CAP_ADDR, 32'd1023);
            endcase
         end
         no_idle = (p == 4);
         if (p == 2) begin
            // exactly full capacity: 80 characters decode to 60 bytes
            push_text("Basic ");
            repeat (80) push_char(b64_char(6'($urandom_range(0, 63))));
            push_end();
         end
         target = queued_count + PHASE_ITEMS;
         while (queued_count < target) push_random_header();
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
